@@ hdl/dtv_pkg.sv @@
`default_nettype none

package dtv_pkg;

    localparam int unsigned YEAR_W   = 16;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned STAMP_W  = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = STAMP_W;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

    localparam logic [DAY_W-1:0] DAYS_LEAP_FEB = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;

    // multiplicative inverse of 25 mod 2^16 and the largest product of a multiple of 25
    localparam logic [YEAR_W-1:0] INV25 = 16'd23593;
    localparam logic [YEAR_W-1:0] LIM25 = 16'd2621;

    localparam logic [YEAR_W-1:0]   RST_MIN_YEAR   = 16'd1970;
    localparam logic [HOUR_W-1:0]   RST_MAX_HOUR   = 5'd23;
    localparam logic [MINUTE_W-1:0] RST_MAX_MINUTE = 6'd59;
    localparam logic [SECOND_W-1:0] RST_MAX_SECOND = 6'd59;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_MONTH  = 3'd1,
        ST_YEAR   = 3'd2,
        ST_DAY    = 3'd3,
        ST_HOUR   = 3'd4,
        ST_MINUTE = 3'd5,
        ST_SECOND = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        POS_WITHIN = 2'd0,
        POS_BEFORE = 2'd1,
        POS_AFTER  = 2'd2
    } pos_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_YEAR      = 3'd0,
        REG_MAX_HOUR      = 3'd1,
        REG_MAX_MINUTE    = 3'd2,
        REG_MAX_SECOND    = 3'd3,
        REG_WINDOW_START  = 3'd4,
        REG_WINDOW_END    = 3'd5,
        REG_START_ENABLED = 3'd6,
        REG_END_ENABLED   = 3'd7
    } cfg_index_t;

    // field order matches the packed window stamp layout
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } stamp_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   min_year;
        logic [HOUR_W-1:0]   max_hour;
        logic [MINUTE_W-1:0] max_minute;
        logic [SECOND_W-1:0] max_second;
        logic [STAMP_W-1:0]  window_start;
        logic [STAMP_W-1:0]  window_end;
        logic                start_enabled;
        logic                end_enabled;
    } cfg_t;

endpackage

`default_nettype wire

@@ hdl/dtv_check.sv @@
`default_nettype none

module dtv_check
    import dtv_pkg::*;
(
    input  wire stamp_t stamp,
    input  wire cfg_t   cfg,
    output status_t     status,
    output pos_t        position
);

    logic [YEAR_W-1:0] year_x_inv;
    logic              div4;
    logic              div25;
    logic              div400;
    logic              leap;
    logic [DAY_W-1:0]  month_days;
    logic [STAMP_W-1:0] stamp_bits;

    // year divisible by 25 iff year * inv(25) mod 2^16 stays at or below 65535/25
    assign year_x_inv = YEAR_W'(stamp.year * INV25);
    assign div25      = (year_x_inv <= LIM25);
    assign div4       = (stamp.year[1:0] == 2'd0);
    assign div400     = (stamp.year[3:0] == 4'd0) && div25;
    assign leap       = (div4 && !div25) || div400;

    always_comb begin
        case (stamp.month) inside
            MONTH_FEB: month_days = leap ? DAYS_LEAP_FEB : DAYS_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_days = DAYS_SHORT;
            default: month_days = DAYS_LONG;
        endcase
    end

    always_comb begin
        if (stamp.month == '0 || stamp.month > MONTH_MAX) begin
            status = ST_MONTH;
        end else if (stamp.year < cfg.min_year) begin
            status = ST_YEAR;
        end else if (stamp.day == '0 || stamp.day > month_days) begin
            status = ST_DAY;
        end else if (stamp.hour > cfg.max_hour) begin
            status = ST_HOUR;
        end else if (stamp.minute > cfg.max_minute) begin
            status = ST_MINUTE;
        end else if (stamp.second > cfg.max_second) begin
            status = ST_SECOND;
        end else begin
            status = ST_OK;
        end
    end

    assign stamp_bits = stamp;

    always_comb begin
        if (cfg.start_enabled && stamp_bits < cfg.window_start) begin
            position = POS_BEFORE;
        end else if (cfg.end_enabled && stamp_bits > cfg.window_end) begin
            position = POS_AFTER;
        end else begin
            position = POS_WITHIN;
        end
    end

endmodule

`default_nettype wire

@@ hdl/datetime_validate_window_check.sv @@
`default_nettype none

// Validates one calendar timestamp per item and places it against an optional
// inclusive start/end window. status reports the first failing check in the order
// month, year, day (Gregorian month length), hour, minute, second; window_position
// is computed from the raw field bits whatever the status. The block takes one
// item every cycle while the result side is not stalled: an input register
// feeds one pass of compare logic and a single year multiply into the result
// register, so an accepted item passes the input register and then the result
// register before its result is valid, and a stalled result does not stop the
// input side until both registers are full. Configuration writes take effect on
// the next cycle and are meant for while the block is idle.
module datetime_validate_window_check
    import dtv_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [YEAR_W-1:0]     s_year,
    input  wire logic [MONTH_W-1:0]    s_month,
    input  wire logic [DAY_W-1:0]      s_day,
    input  wire logic [HOUR_W-1:0]     s_hour,
    input  wire logic [MINUTE_W-1:0]   s_minute,
    input  wire logic [SECOND_W-1:0]   s_second,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_status,
    output logic [1:0]                 m_window_position
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;

    logic    in_valid_reg;
    logic    in_valid_next;
    stamp_t  in_stamp_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    status_t out_status_reg;
    pos_t    out_pos_reg;

    status_t chk_status;
    pos_t    chk_position;
    logic    in_load;
    logic    out_load;

    // config registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_MIN_YEAR:      cfg_next.min_year      = cfg_wr_data[YEAR_W-1:0];
                REG_MAX_HOUR:      cfg_next.max_hour      = cfg_wr_data[HOUR_W-1:0];
                REG_MAX_MINUTE:    cfg_next.max_minute    = cfg_wr_data[MINUTE_W-1:0];
                REG_MAX_SECOND:    cfg_next.max_second    = cfg_wr_data[SECOND_W-1:0];
                REG_WINDOW_START:  cfg_next.window_start  = cfg_wr_data[STAMP_W-1:0];
                REG_WINDOW_END:    cfg_next.window_end    = cfg_wr_data[STAMP_W-1:0];
                REG_START_ENABLED: cfg_next.start_enabled = cfg_wr_data[0];
                REG_END_ENABLED:   cfg_next.end_enabled   = cfg_wr_data[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_year      <= RST_MIN_YEAR;
            cfg_reg.max_hour      <= RST_MAX_HOUR;
            cfg_reg.max_minute    <= RST_MAX_MINUTE;
            cfg_reg.max_second    <= RST_MAX_SECOND;
            cfg_reg.window_start  <= '0;
            cfg_reg.window_end    <= '0;
            cfg_reg.start_enabled <= 1'b0;
            cfg_reg.end_enabled   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // two-register pipeline handshake
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    assign in_valid_next  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_stamp_reg.year   <= s_year;
            in_stamp_reg.month  <= s_month;
            in_stamp_reg.day    <= s_day;
            in_stamp_reg.hour   <= s_hour;
            in_stamp_reg.minute <= s_minute;
            in_stamp_reg.second <= s_second;
        end
    end

    dtv_check u_check (
        .stamp    (in_stamp_reg),
        .cfg      (cfg_reg),
        .status   (chk_status),
        .position (chk_position)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= chk_status;
            out_pos_reg    <= chk_position;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = out_status_reg;
    assign m_window_position = out_pos_reg;

    // item taken at the input sits in the input register next cycle
    a_in_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted item not held in input register");

    // an item moved out of the input register shows as a result next cycle
    a_out_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && (!m_valid || m_ready) |=> m_valid)
        else $error("result register did not take the item");

    // no item leaves the input register while the result side is blocked
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_valid && !m_ready |=> in_valid_reg && $stable(in_stamp_reg))
        else $error("input register lost an item during a stall");

    // results never exist straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
